// ----- sv/pcpa_pkg.sv -----
// Shared types and constants of the per-CPU page free-list allocator.
// No dependencies.
package pcpa_pkg;

	localparam logic       CMD_FREE  = 1'b0;
	localparam logic       CMD_ALLOC = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_NOMEM = 2'd2;

	localparam logic [1:0] REG_POOL_BASE  = 2'd0;
	localparam logic [1:0] REG_LOW_LIMIT  = 2'd1;
	localparam logic [1:0] REG_HIGH_LIMIT = 2'd2;

	localparam logic [31:0] POOL_BASE_RST  = 32'h8000_0000;
	localparam logic [31:0] LOW_LIMIT_RST  = 32'h8000_0000;
	localparam logic [31:0] HIGH_LIMIT_RST = 32'h8800_0000;

	localparam int         Q_DEPTH = 2;
	localparam logic [1:0] Q_FULL  = 2'd2;

	typedef struct packed {
		logic       is_alloc;
		logic       bad;
		logic [2:0] cpu;
	} pcpa_cmd_t;

endpackage

// ----- sv/pcpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/pcpa_front.sv -----
// Front end: accepts commands, checks free addresses, queues classified commands.
// Depends on pcpa_pkg.
module pcpa_front #(
	parameter int CPU_COUNT  = 8,
	parameter int POOL_PAGES = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          cmd,
	input  logic [2:0]                    cpu_num,
	input  logic [31:0]                   page_addr,
	input  logic [31:0]                   pool_base,
	input  logic [31:0]                   low_limit,
	input  logic [31:0]                   high_limit,
	output logic                          busy,
	output logic                          q_valid,
	output pcpa_pkg::pcpa_cmd_t           q_cmd,
	output logic [$clog2(POOL_PAGES)-1:0] q_idx,
	input  logic                          q_deq
);
	import pcpa_pkg::*;

	localparam int IDX_W = $clog2(POOL_PAGES);
	localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

	logic [31:0] base;
	logic [31:0] idx32;
	logic        bad;
	logic        push;
	pcpa_cmd_t   in_cmd;

	pcpa_cmd_t        ent_cmd_q [Q_DEPTH];
	logic [IDX_W-1:0] ent_idx_q [Q_DEPTH];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign base  = pool_base & ~PAGE_MASK;
	assign idx32 = (page_addr - base) >> PAGE_SHIFT;

	always_comb begin
		bad = 1'b0;
		if ((page_addr & PAGE_MASK) != 32'd0 || page_addr < low_limit ||
		    page_addr >= high_limit || page_addr < base) begin
			bad = 1'b1;
		end
		if (idx32 >= 32'(POOL_PAGES) || 32'(cpu_num) >= 32'(CPU_COUNT)) begin
			bad = 1'b1;
		end
	end

	assign in_cmd.is_alloc = (cmd == CMD_ALLOC);
	assign in_cmd.bad      = bad;
	assign in_cmd.cpu      = cpu_num;

	assign busy    = (cnt_q == Q_FULL);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_cmd_q[rp_q];
	assign q_idx   = ent_idx_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_cmd_q[wp_q] <= in_cmd;
			ent_idx_q[wp_q] <= IDX_W'(idx32);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_deq) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_deq};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_FULL)
		else $error("queue count exceeds depth");

	a_deq_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_deq |-> cnt_q != 2'd0)
		else $error("dequeue from empty queue");

endmodule

// ----- sv/pcpa_back.sv -----
// Back end: per-CPU list heads, next-link table, push/pop and steal search.
// Depends on pcpa_pkg and pcpa_ram.
module pcpa_back #(
	parameter int CPU_COUNT  = 8,
	parameter int POOL_PAGES = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  pcpa_pkg::pcpa_cmd_t           q_cmd,
	input  logic [$clog2(POOL_PAGES)-1:0] q_idx,
	output logic                          q_deq,
	input  logic [31:0]                   pool_base,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [31:0]                   granted_addr,
	output logic [2:0]                    served_by,
	output logic                          stolen
);
	import pcpa_pkg::*;

	localparam int IDX_W  = $clog2(POOL_PAGES);
	localparam int HEAD_W = $clog2(POOL_PAGES + 1);
	localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_POP  = 2'b10
	} bk_state_t;

	bk_state_t         state_q;
	logic [HEAD_W-1:0] head_q [CPU_COUNT];
	logic [CPU_W-1:0]  from_q;
	logic              steal_q;
	logic [HEAD_W-1:0] top_q;

	logic [CPU_COUNT-1:0] head_ne;
	logic                 cpu_ok;
	logic [CPU_W-1:0]     own;
	logic                 found;
	logic [CPU_W-1:0]     src;
	logic                 steal;
	logic                 ram_we;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [HEAD_W-1:0]    ram_rdata;
	logic [31:0]          base;

	assign base   = pool_base & ~PAGE_MASK;
	assign cpu_ok = 32'(q_cmd.cpu) < 32'(CPU_COUNT);
	assign own    = CPU_W'(q_cmd.cpu);

	always_comb begin
		for (int i = 0; i < CPU_COUNT; i++) begin
			head_ne[i] = (head_q[i] != '0);
		end
	end

	always_comb begin
		found = 1'b0;
		src   = '0;
		steal = 1'b0;
		for (int i = CPU_COUNT - 1; i >= 0; i--) begin
			if (head_ne[i] && 32'(i) != 32'(q_cmd.cpu)) begin
				found = 1'b1;
				src   = CPU_W'(i);
				steal = 1'b1;
			end
		end
		if (cpu_ok && head_ne[own]) begin
			found = 1'b1;
			src   = own;
			steal = 1'b0;
		end
	end

	assign q_deq     = (state_q == BK_IDLE) && q_valid;
	assign ram_we    = q_deq && !q_cmd.is_alloc && !q_cmd.bad;
	assign ram_re    = q_deq && q_cmd.is_alloc && found;
	assign ram_raddr = IDX_W'(head_q[src] - 1'b1);

	pcpa_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(POOL_PAGES)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_idx),
		.wdata(head_q[own]),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			done    <= 1'b0;
			for (int i = 0; i < CPU_COUNT; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					if (q_deq) begin
						if (ram_re) begin
							head_q[src] <= '0;
							state_q     <= BK_POP;
						end else begin
							done <= 1'b1;
							if (ram_we) begin
								head_q[own] <= HEAD_W'(q_idx) + 1'b1;
							end
						end
					end
				end
				BK_POP: begin
					head_q[from_q] <= ram_rdata;
					done           <= 1'b1;
					state_q        <= BK_IDLE;
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				status       <= ST_DONE;
				granted_addr <= 32'd0;
				served_by    <= 3'd0;
				stolen       <= 1'b0;
				if (ram_re) begin
					from_q  <= src;
					steal_q <= steal;
					top_q   <= head_q[src];
				end
				if (q_deq && !ram_re) begin
					if (q_cmd.is_alloc) begin
						status <= ST_NOMEM;
					end else if (q_cmd.bad) begin
						status <= ST_BAD;
					end else begin
						served_by <= q_cmd.cpu;
					end
				end
			end
			BK_POP: begin
				status       <= ST_DONE;
				granted_addr <= base + (32'(IDX_W'(top_q - 1'b1)) << PAGE_SHIFT);
				served_by    <= 3'(from_q);
				stolen       <= steal_q;
			end
			default: begin
				status <= ST_DONE;
			end
		endcase
	end

	a_pop_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_POP |=> state_q == BK_IDLE && done)
		else $error("pop did not finish in one cycle");

	a_read_to_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> state_q == BK_POP && !done)
		else $error("link read not followed by pop");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_DONE |-> granted_addr == 32'd0 && served_by == 3'd0 && !stolen)
		else $error("error result carries page data");

	a_no_write_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_POP |-> !ram_we && !q_deq)
		else $error("new command taken during pop");

endmodule

// ----- sv/per_cpu_page_free_list_allocator_top.sv -----
// Top level of the per-CPU page free-list allocator: configuration registers,
// front end and back end. Depends on pcpa_pkg, pcpa_front, pcpa_back, pcpa_ram.
//
// Usage:
//   Command channel: a command is taken at a rising edge with start high and
//   busy low. cmd selects free (page_addr, cpu_num) or allocate (cpu_num).
//   Result channel: exactly one result per command, shown for one cycle with
//   done high; the receiver cannot stall, results are never held.
//   Config channel: cfg_valid/cfg_ready write register cfg_index with
//   cfg_data (0 pool_base, 1 low_limit, 2 high_limit, others ignored);
//   cfg_ready is always high. Write only while no command is outstanding.
// Completion: a free or a failed allocate shows done in the cycle after the back
//   end takes it from the two-entry command queue; a successful allocate also
//   passes through the pop state, where no new command is taken, until the
//   list head updates from the registered read of the next-link RAM.
// Throughput: one free per cycle while busy is low; busy is high while the
//   command queue holds two entries.
// Reset: all lists empty, registers to their defaults; the next-link RAM is
//   not cleared and needs no start-up pass.
module per_cpu_page_free_list_allocator_top #(
	parameter int CPU_COUNT  = 8,
	parameter int POOL_PAGES = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [2:0]  cpu_num,
	input  logic [31:0] page_addr,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] granted_addr,
	output logic [2:0]  served_by,
	output logic        stolen,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pcpa_pkg::*;

	localparam int IDX_W = $clog2(POOL_PAGES);

	logic [31:0]      pool_base_q;
	logic [31:0]      low_limit_q;
	logic [31:0]      high_limit_q;
	logic             q_valid;
	logic             q_deq;
	pcpa_cmd_t        q_cmd;
	logic [IDX_W-1:0] q_idx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= POOL_BASE_RST;
			low_limit_q  <= LOW_LIMIT_RST;
			high_limit_q <= HIGH_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POOL_BASE:  pool_base_q  <= cfg_data;
				REG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pcpa_front #(
		.CPU_COUNT (CPU_COUNT),
		.POOL_PAGES(POOL_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.cpu_num   (cpu_num),
		.page_addr (page_addr),
		.pool_base (pool_base_q),
		.low_limit (low_limit_q),
		.high_limit(high_limit_q),
		.busy      (busy),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_idx     (q_idx),
		.q_deq     (q_deq)
	);

	pcpa_back #(
		.CPU_COUNT (CPU_COUNT),
		.POOL_PAGES(POOL_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_idx       (q_idx),
		.q_deq       (q_deq),
		.pool_base   (pool_base_q),
		.done        (done),
		.status      (status),
		.granted_addr(granted_addr),
		.served_by   (served_by),
		.stolen      (stolen)
	);

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for per_cpu_page_free_list_allocator_top: queued free/alloc
// transactions, an in-order predictor of the per-CPU page lists and a field checker.
// Depends on pcpa_pkg and the allocator RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pcpa_pkg::*;

	localparam int N_CPU       = 8;
	localparam int N_PAGES     = 32768;
	localparam int PG_SHIFT    = 12;
	localparam int STALL_LIMIT = 5000;
	localparam int N_PHASES    = 7;
	localparam int OPS_PER_PHASE = 255;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic        op;
		logic [2:0]  cpu;
		logic [31:0] addr;
	} page_op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted;
		logic [2:0]  served;
		logic        stolen;
	} page_outcome_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [6:0]  gap;
	} phase_cfg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        cmd = CMD_FREE;
	logic [2:0]  cpu_num = 3'd0;
	logic [31:0] page_addr = 32'd0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = REG_POOL_BASE;
	logic [31:0] cfg_data = 32'd0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [31:0] granted_addr;
	logic [2:0]  served_by;
	logic        stolen;
	logic        cfg_ready;

	page_op_t      page_op_q[$];
	page_outcome_t outcome_q[$];

	// predictor state: page index plus one, zero = empty / end of list
	bit [15:0] head_of [0:N_CPU-1];
	bit [15:0] link_of [0:N_PAGES-1];
	bit [31:0] base_r = POOL_BASE_RST;
	bit [31:0] low_r  = LOW_LIMIT_RST;
	bit [31:0] high_r = HIGH_LIMIT_RST;

	bit op_taken  = 1'b0;
	bit cfg_taken = 1'b0;
	int gap_pct   = 0;
	int mismatches = 0;
	int quiet     = 0;

	per_cpu_page_free_list_allocator_top #(
		.CPU_COUNT(N_CPU),
		.POOL_PAGES(N_PAGES),
		.PAGE_SHIFT(PG_SHIFT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cpu_num(cpu_num),
		.page_addr(page_addr),
		.done(done),
		.status(status),
		.granted_addr(granted_addr),
		.served_by(served_by),
		.stolen(stolen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit [15:0] pop_page(input int c);
		bit [15:0] top;
		top = head_of[c];
		if (top != 16'd0)
			head_of[c] = link_of[top - 16'd1];
		return top;
	endfunction

	function automatic page_outcome_t apply_page_op(input logic op, input logic [2:0] cpu,
			input logic [31:0] addr);
		page_outcome_t res;
		bit [31:0] base_al;
		bit [31:0] idx;
		bit [15:0] got;
		bit bad;
		int from;
		res = '0;
		base_al = (base_r >> PG_SHIFT) << PG_SHIFT;
		idx = 32'd0;
		if (op == CMD_FREE) begin
			bad = (addr[PG_SHIFT-1:0] != '0) || addr < low_r || addr >= high_r;
			if (addr < base_al)
				bad = 1'b1;
			else
				idx = (addr - base_al) >> PG_SHIFT;
			if (idx >= N_PAGES || cpu >= N_CPU)
				bad = 1'b1;
			if (bad) begin
				res.status = ST_BAD;
			end else begin
				link_of[idx] = head_of[cpu];
				head_of[cpu] = idx[15:0] + 16'd1;
				res.status = ST_DONE;
				res.served = cpu;
			end
		end else begin
			got = 16'd0;
			from = 0;
			if (cpu < N_CPU) begin
				got = pop_page(cpu);
				from = cpu;
			end
			for (int i = 0; i < N_CPU; i++) begin
				if (got == 16'd0 && i != cpu) begin
					got = pop_page(i);
					if (got != 16'd0) begin
						from = i;
						res.stolen = 1'b1;
					end
				end
			end
			if (got == 16'd0) begin
				res.status = ST_NOMEM;
				res.stolen = 1'b0;
			end else begin
				res.status = ST_DONE;
				res.granted = base_al + ({16'd0, got - 16'd1} << PG_SHIFT);
				res.served = from[2:0];
			end
		end
		return res;
	endfunction

	// result check, then prediction of the transaction accepted at this edge
	always @(posedge clk) begin : monitor
		page_outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result with no pending transaction");
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (granted_addr !== want.granted) begin
						$error("granted_addr: expected %h, got %h", want.granted, granted_addr);
						mismatches++;
					end
					if (served_by !== want.served) begin
						$error("served_by: expected %0d, got %0d", want.served, served_by);
						mismatches++;
					end
					if (stolen !== want.stolen) begin
						$error("stolen: expected %0d, got %0d", want.stolen, stolen);
						mismatches++;
					end
				end
			end
			op_taken = start && !busy;
			cfg_taken = cfg_valid && cfg_ready;
			if (op_taken)
				outcome_q.push_back(apply_page_op(cmd, cpu_num, page_addr));
			if (cfg_taken) begin
				case (cfg_index)
				REG_POOL_BASE: base_r = cfg_data;
				REG_LOW_LIMIT: low_r = cfg_data;
				REG_HIGH_LIMIT: high_r = cfg_data;
				default: ;
				endcase
			end
			if (op_taken || done || cfg_taken)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(negedge clk) begin : driver
		page_op_t nxt;
		if (arst_n && (!start || op_taken)) begin
			if (page_op_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				nxt = page_op_q.pop_front();
				start <= 1'b1;
				cmd <= nxt.op;
				cpu_num <= nxt.cpu;
				page_addr <= nxt.addr;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic phase_cfg_t phase_cfg(input int p);
		case (p)
		1: return '{32'h0000_0FFF, 32'h0000_0000, 32'hFFFF_FFFF, 7'd77};
		2: return '{32'hFFFF_F000, 32'h0000_0000, 32'hFFFF_FFFF, 7'd0};
		3: return '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 7'd35};
		4: return '{32'h4000_0000, 32'h4001_0000, 32'h4008_0000, 7'd77};
		5: return '{POOL_BASE_RST, LOW_LIMIT_RST, HIGH_LIMIT_RST, 7'd0};
		6: return '{32'h1234_5678, 32'h1000_0000, 32'hFFFF_FFFF, 7'd35};
		default: return '{POOL_BASE_RST, LOW_LIMIT_RST, HIGH_LIMIT_RST, 7'd0};
		endcase
	endfunction

	task automatic push_free(input logic [2:0] cpu, input logic [31:0] addr);
		page_op_q.push_back('{CMD_FREE, cpu, addr});
	endtask

	task automatic push_alloc(input logic [2:0] cpu);
		page_op_q.push_back('{CMD_ALLOC, cpu, 32'($urandom)});
	endtask

	task automatic queue_random_ops(input phase_cfg_t pc, input int count);
		logic [31:0] base_al;
		logic [31:0] addr;
		int pick;
		base_al = (pc.base >> PG_SHIFT) << PG_SHIFT;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if ($urandom_range(9) == 0)
				addr = base_al + (32'($urandom_range(N_PAGES - 1)) << PG_SHIFT);
			else
				addr = base_al + (32'($urandom_range(63)) << PG_SHIFT);
			if (pick < 40) begin
				push_alloc(3'($urandom));
			end else if (pick < 85) begin
				push_free(3'($urandom), addr);
			end else begin
				case ($urandom_range(3))
				0: addr = $urandom;
				1: addr = addr | 32'($urandom_range(4095));
				2: addr = pc.hi;
				default: addr = pc.lo - 32'd4096;
				endcase
				push_free(3'($urandom), addr);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (page_op_q.size() != 0 || start || outcome_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	initial begin
		phase_cfg_t pc;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: empty lists, pool edges, bad frees, stealing, double free ring
		push_alloc(3'd0);
		push_free(3'd0, 32'h8000_0000);
		push_free(3'd7, 32'h87FF_F000);
		push_free(3'd1, 32'h8800_0000);
		push_free(3'd1, 32'h7FFF_F000);
		push_free(3'd2, 32'h8000_0001);
		push_free(3'd2, 32'h8000_0800);
		push_free(3'd3, 32'hFFFF_FFFF);
		push_free(3'd3, 32'h0000_0000);
		push_alloc(3'd0);
		push_alloc(3'd3);
		push_alloc(3'd5);
		push_free(3'd2, 32'h8000_1000);
		push_free(3'd2, 32'h8000_1000);
		push_alloc(3'd2);
		push_alloc(3'd2);
		push_alloc(3'd2);
		push_free(3'd4, 32'h8000_2000);
		push_free(3'd6, 32'h8000_3000);
		push_alloc(3'd1);
		push_free(3'd5, 32'h8123_4000);
		push_alloc(3'd5);

		for (int p = 0; p < N_PHASES; p++) begin
			pc = phase_cfg(p);
			if (p > 0) begin
				wait_idle();
				write_reg(REG_POOL_BASE, pc.base);
				write_reg(REG_LOW_LIMIT, pc.lo);
				write_reg(REG_HIGH_LIMIT, pc.hi);
				if (p == 3)
					write_reg(REG_UNUSED, $urandom);
			end
			gap_pct = pc.gap;
			queue_random_ops(pc, OPS_PER_PHASE);
		end

		wait_idle();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pcpa_pkg.sv
sv/pcpa_ram.sv
sv/pcpa_front.sv
sv/pcpa_back.sv
sv/per_cpu_page_free_list_allocator_top.sv
tb/testbench.sv
